// ===== rtl/arx_plant_model_step_top_defines.svh =====
// ---------------------------------------------------------------------------
// arx plant model step - assertion macros
// shared property helpers for the top level checks
// ---------------------------------------------------------------------------
`ifndef ARX_PLANT_MODEL_STEP_TOP_DEFINES_SVH
`define ARX_PLANT_MODEL_STEP_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ARXPS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("arxps check failed");

// next-cycle implication, disabled during reset
`define ARXPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("arxps check failed");

`endif

// ===== rtl/arxps_pkg.sv =====
// ---------------------------------------------------------------------------
// arxps_pkg
// constants, codes and controller/datapath types of the arx plant model
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package arxps_pkg;

  localparam int A_TAPS      = 4;
  localparam int B_TAPS      = 4;
  localparam int MAX_DELAY   = 8;
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 16;
  localparam int COEF_FRAC   = 13;
  localparam int IN_DEPTH    = B_TAPS + MAX_DELAY;

  localparam int CFG_DATA_BITS  = 64;
  localparam int CFG_INDEX_BITS = 3;
  localparam int DELAY_BITS     = 4;

  localparam int STEPS      = A_TAPS + B_TAPS;
  localparam int STEP_BITS  = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int A_IDX_BITS = (A_TAPS > 1) ? $clog2(A_TAPS) : 1;
  localparam int B_IDX_BITS = (B_TAPS > 1) ? $clog2(B_TAPS) : 1;
  localparam int IDX_BITS   = $clog2(IN_DEPTH);
  localparam int PROD_BITS  = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_BITS   = PROD_BITS + STEP_BITS + 1;
  localparam int Q_BITS     = ACC_BITS - COEF_FRAC;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_A_COEFS     = 3'd0,
    REG_B_COEFS     = 3'd1,
    REG_INPUT_DELAY = 3'd2,
    REG_U_LOW       = 3'd3,
    REG_U_HIGH      = 3'd4,
    REG_Y_LOW       = 3'd5,
    REG_Y_HIGH      = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic                 load;
    logic                 mul_en;
    logic [STEP_BITS-1:0] step;
    logic                 acc_en;
    logic                 finish;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/arxps_ctrl.sv =====
// ---------------------------------------------------------------------------
// arxps_ctrl
// sequencer: accept, eight multiply steps, drain, result write
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arxps_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire arxps_pkg::dp_status_t status,
  output arxps_pkg::dp_cmd_t         cmd
);
  import arxps_pkg::*;

  ctrl_state_t          state, state_next;
  logic [STEP_BITS-1:0] count, count_next;

  localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(STEPS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    case (state)
      ST_IDLE: begin
        count_next = '0;
        if (in_valid) state_next = ST_MAC;
      end
      ST_MAC: begin
        count_next = count + 1'b1;
        if (count == LAST_STEP) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.mul_en = 1'b0;
    cmd.step   = count;
    cmd.acc_en = 1'b0;
    cmd.finish = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_MAC: begin
        cmd.mul_en = 1'b1;
        // the product of the previous step comes from the product register, so no accumulate on the first step
        cmd.acc_en = (count != '0);
      end
      ST_DRAIN: begin
        cmd.acc_en = 1'b1;
      end
      ST_DONE: begin
        cmd.finish = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/arxps_datapath.sv =====
// ---------------------------------------------------------------------------
// arxps_datapath
// configuration registers, sample histories, shared mac and output stage
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arxps_datapath (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_we,
  input  wire logic [arxps_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [arxps_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  wire logic signed [arxps_pkg::SAMPLE_BITS-1:0] u_sample,
  output logic signed [arxps_pkg::SAMPLE_BITS-1:0]   y_sample,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  input  wire arxps_pkg::dp_cmd_t                    cmd,
  output arxps_pkg::dp_status_t                      status
);
  import arxps_pkg::*;

  logic [CFG_DATA_BITS-1:0]      a_coefs;
  logic [CFG_DATA_BITS-1:0]      b_coefs;
  logic [DELAY_BITS-1:0]         input_delay;
  logic signed [SAMPLE_BITS-1:0] u_low, u_high, y_low, y_high;

  logic signed [SAMPLE_BITS-1:0] in_hist  [IN_DEPTH];
  logic signed [SAMPLE_BITS-1:0] out_hist [A_TAPS];

  logic signed [COEF_BITS-1:0]   a_tap [A_TAPS];
  logic signed [COEF_BITS-1:0]   b_tap [B_TAPS];

  logic [DELAY_BITS-1:0]         delay_eff;
  logic [A_IDX_BITS-1:0]         a_j;
  logic [B_IDX_BITS-1:0]         b_j;
  logic [STEP_BITS-1:0]          b_step;
  logic [IDX_BITS-1:0]           hist_idx;
  logic                          is_a;
  logic signed [COEF_BITS-1:0]   coef_sel;
  logic signed [SAMPLE_BITS-1:0] samp_sel;

  logic signed [PROD_BITS-1:0]   prod;
  logic                          prod_sub;
  logic signed [ACC_BITS-1:0]    prod_ext;
  logic signed [ACC_BITS-1:0]    acc;

  logic signed [SAMPLE_BITS-1:0] u_clamped;
  logic signed [Q_BITS-1:0]      q;
  logic signed [SAMPLE_BITS-1:0] q_sat;
  logic signed [SAMPLE_BITS-1:0] y_new;

  localparam logic [DELAY_BITS-1:0] DELAY_MAX = DELAY_BITS'(MAX_DELAY);
  localparam logic signed [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      a_coefs     <= '0;
      b_coefs     <= '0;
      input_delay <= DELAY_BITS'(1);
      u_low       <= SAT_MIN;
      u_high      <= SAT_MAX;
      y_low       <= SAT_MIN;
      y_high      <= SAT_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_A_COEFS:     a_coefs     <= cfg_data;
        REG_B_COEFS:     b_coefs     <= cfg_data;
        REG_INPUT_DELAY: input_delay <= cfg_data[DELAY_BITS-1:0];
        REG_U_LOW:       u_low       <= cfg_data[SAMPLE_BITS-1:0];
        REG_U_HIGH:      u_high      <= cfg_data[SAMPLE_BITS-1:0];
        REG_Y_LOW:       y_low       <= cfg_data[SAMPLE_BITS-1:0];
        REG_Y_HIGH:      y_high      <= cfg_data[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int j = 0; j < A_TAPS; j++) a_tap[j] = a_coefs[COEF_BITS*j +: COEF_BITS];
    for (int j = 0; j < B_TAPS; j++) b_tap[j] = b_coefs[COEF_BITS*j +: COEF_BITS];
  end

  // dead time of zero acts as one, above the line length it saturates
  always_comb begin
    if (input_delay == '0) delay_eff = DELAY_BITS'(1);
    else if (input_delay > DELAY_MAX) delay_eff = DELAY_MAX;
    else delay_eff = input_delay;
  end

  // bottom limit is tested first, so crossed limits give the low value for samples below it, else the high value
  always_comb begin
    if (u_sample < u_low) u_clamped = u_low;
    else if (u_sample > u_high) u_clamped = u_high;
    else u_clamped = u_sample;
  end

  // tap selection: feedback taps first, then input taps
  always_comb begin
    is_a     = (cmd.step < STEP_BITS'(A_TAPS));
    b_step   = cmd.step - STEP_BITS'(A_TAPS);
    a_j      = cmd.step[A_IDX_BITS-1:0];
    b_j      = b_step[B_IDX_BITS-1:0];
    hist_idx = IDX_BITS'(delay_eff) + IDX_BITS'(b_j);
    if (is_a) begin
      coef_sel = a_tap[a_j];
      samp_sel = out_hist[a_j];
    end else begin
      coef_sel = b_tap[b_j];
      samp_sel = in_hist[hist_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod     <= coef_sel * samp_sel;
      prod_sub <= is_a;
    end
  end

  assign prod_ext = {{(ACC_BITS-PROD_BITS){prod[PROD_BITS-1]}}, prod};

  always_ff @(posedge clk) begin
    if (cmd.load) acc <= '0;
    else if (cmd.acc_en) acc <= prod_sub ? acc - prod_ext : acc + prod_ext;
  end

  // floor shift is the upper slice; saturate when the dropped upper bits and the sign bit disagree, then clamp
  always_comb begin
    q = acc[ACC_BITS-1:COEF_FRAC];
    if (q[Q_BITS-1:SAMPLE_BITS-1] == '0 || q[Q_BITS-1:SAMPLE_BITS-1] == '1) begin
      q_sat = q[SAMPLE_BITS-1:0];
    end else begin
      q_sat = q[Q_BITS-1] ? SAT_MIN : SAT_MAX;
    end
    if (q_sat < y_low) y_new = y_low;
    else if (q_sat > y_high) y_new = y_high;
    else y_new = q_sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < IN_DEPTH; i++) in_hist[i] <= '0;
      for (int i = 0; i < A_TAPS; i++) out_hist[i] <= '0;
    end else begin
      if (cmd.load) begin
        for (int i = IN_DEPTH - 1; i > 0; i--) in_hist[i] <= in_hist[i-1];
        in_hist[0] <= u_clamped;
      end
      if (cmd.finish) begin
        for (int i = A_TAPS - 1; i > 0; i--) out_hist[i] <= out_hist[i-1];
        out_hist[0] <= y_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) y_sample <= y_new;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.finish) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  assign status.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

// ===== rtl/arx_plant_model_step_top.sv =====
// ---------------------------------------------------------------------------
// arx_plant_model_step_top
// arx plant model: one clamped output sample per input sample
// ---------------------------------------------------------------------------
// Each transfer on the input side yields exactly one output transfer. One shared
// 16x16 multiplier works through the four feedback and four input taps one per
// cycle, then a drain state accumulates the last product and a write state
// shifts, saturates, clamps and writes the output register; only then is the
// next item accepted. The output register lets the next sample be accepted
// while a result waits; if it is still full at the write state, the sequencer
// holds there. The user must write configuration through cfg_we / cfg_index /
// cfg_data only while no sample is in work; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
`include "arx_plant_model_step_top_defines.svh"

module arx_plant_model_step_top (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     cfg_we,
  input  wire logic [arxps_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  wire logic [arxps_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  input  wire logic                                     in_valid,
  output logic                                          in_ready,
  input  wire logic signed [arxps_pkg::SAMPLE_BITS-1:0] u_sample,
  output logic                                          out_valid,
  input  wire logic                                     out_ready,
  output logic signed [arxps_pkg::SAMPLE_BITS-1:0]      y_sample
);
  import arxps_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  arxps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  arxps_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .u_sample  (u_sample),
    .y_sample  (y_sample),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  `ARXPS_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  `ARXPS_ASSERT_NEXT(a_load_starts_mac, clk, rst, cmd.load, cmd.mul_en)
  `ARXPS_ASSERT_SAME(a_acc_follows_mul, clk, rst, cmd.acc_en, $past(cmd.mul_en))
  `ARXPS_ASSERT_SAME(a_finish_needs_room, clk, rst, cmd.finish, !out_valid || out_ready)

endmodule

`default_nettype wire
